>>> hw/rtl/tcp_syn_auth_filter_macros.svh
// Assertion macros used by the filter back end (tsa_back).
`ifndef TCP_SYN_AUTH_FILTER_MACROS_SVH
`define TCP_SYN_AUTH_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tsa_pkg.sv
// Types, constants and sizes shared by the SYN authentication filter.
`default_nettype none

package tsa_pkg;

  localparam int ALLOW_DEPTH = 256;
  localparam int PEND_DEPTH  = 1024;
  localparam int MAX_FRAME   = 2048;
  localparam int FRAME_SLACK = 2;

  localparam int ALLOW_AW  = $clog2(ALLOW_DEPTH);
  localparam int PEND_AW   = $clog2(PEND_DEPTH);
  localparam int CNT_AW    = (ALLOW_AW > PEND_AW) ? ALLOW_AW : PEND_AW;
  localparam int CLR_DEPTH = (ALLOW_DEPTH > PEND_DEPTH) ? ALLOW_DEPTH : PEND_DEPTH;

  localparam int IN_W     = 280;
  localparam int OUT_W    = 168;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  // register indexes
  localparam logic [2:0] REG_WATCH0 = 3'd0;
  localparam logic [2:0] REG_WATCH1 = 3'd1;
  localparam logic [2:0] REG_WATCH2 = 3'd2;
  localparam logic [2:0] REG_WATCH3 = 3'd3;
  localparam logic [2:0] REG_WCOUNT = 3'd4;
  localparam logic [2:0] REG_ALLOW  = 3'd5;
  localparam logic [2:0] REG_WAIT   = 3'd6;
  localparam logic [2:0] REG_SWEEP  = 3'd7;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_SYN,
    OP_ACK
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SYNACK = 2'd1,
    KIND_RST    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ASCAN,
    ST_PSCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [3:0][31:0] watch_addr;
    logic [2:0]       watch_count;
    logic [31:0]      allow_time;
    logic [31:0]      syn_wait_time;
    logic [31:0]      sweep_interval;
  } cfg_t;

  typedef struct packed {
    logic [63:0] now;
    op_t         op;
    logic [63:0] pair;
    logic [31:0] ports;
    logic        flen_ok;
    logic [63:0] exp_syn;
    logic [63:0] exp_allow;
    logic [63:0] next_sweep;
    logic [31:0] seq;
    logic [31:0] seq_inc;
    logic [31:0] ackn;
    logic [31:0] sseq;
  } item_t;

  typedef struct packed {
    logic        pass_to_host;
    kind_t       reply_kind;
    logic [31:0] reply_src_addr;
    logic [31:0] reply_dst_addr;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dst_port;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    logic        table_full;
  } res_t;

  typedef struct packed {
    logic        push;
    logic        full;
  } q_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/tsa_front.sv
// Front end: unpacks a header beat, classifies it and precomputes expiry times.
`default_nettype none

module tsa_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [tsa_pkg::IN_W-1:0] in_tdata,
  input  wire tsa_pkg::cfg_t          cfg,
  input  wire logic                   q_full,
  output logic                        q_push,
  output tsa_pkg::item_t              q_wdata
);

  logic [63:0] now;
  logic        is_tcp;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic        syn_flag;
  logic        ack_flag;
  logic [31:0] seq_num;
  logic [31:0] ack_num;
  logic [31:0] server_seq;
  logic [15:0] frame_length;
  logic [3:0]  hit;
  logic        watched;
  logic        busy_r;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [31:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {33'd0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  assign now          = in_tdata[63:0];
  assign is_tcp       = in_tdata[64];
  assign src_addr     = in_tdata[96:65];
  assign dst_addr     = in_tdata[128:97];
  assign src_port     = in_tdata[144:129];
  assign dst_port     = in_tdata[160:145];
  assign syn_flag     = in_tdata[161];
  assign ack_flag     = in_tdata[162];
  assign seq_num      = in_tdata[194:163];
  assign ack_num      = in_tdata[226:195];
  assign server_seq   = in_tdata[258:227];
  assign frame_length = in_tdata[274:259];

  // a count above four enables all four slots
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hit[i] = (cfg.watch_count > 3'(i)) && (cfg.watch_addr[i] == dst_addr);
    end
  end
  assign watched = |hit;

  // holds off the first beat during reset and in the cycle after reset is released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign in_tready = !q_full && !busy_r;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_wdata            = '0;
    q_wdata.now        = now;
    q_wdata.op         = tsa_pkg::OP_PASS;
    if (is_tcp && watched) begin
      if (syn_flag && !ack_flag) begin
        q_wdata.op = tsa_pkg::OP_SYN;
      end else if (!syn_flag && ack_flag) begin
        q_wdata.op = tsa_pkg::OP_ACK;
      end
    end
    q_wdata.pair       = {src_addr, dst_addr};
    q_wdata.ports      = {src_port, dst_port};
    q_wdata.flen_ok    = {1'b0, frame_length} <= 17'(tsa_pkg::MAX_FRAME - tsa_pkg::FRAME_SLACK);
    q_wdata.exp_syn    = sat_add(now, cfg.syn_wait_time);
    q_wdata.exp_allow  = sat_add(now, cfg.allow_time);
    q_wdata.next_sweep = sat_add(now, cfg.sweep_interval);
    q_wdata.seq        = seq_num;
    q_wdata.seq_inc    = seq_num + 32'd1;
    q_wdata.ackn       = ack_num;
    q_wdata.sseq       = server_seq;
  end

endmodule

`default_nettype wire

>>> hw/rtl/tsa_queue.sv
// Two-entry queue of classified headers between front and back.
`default_nettype none

module tsa_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tsa_pkg::q_ctl_t ctl_in,
  output logic                full,
  input  wire tsa_pkg::item_t wdata,
  output logic                valid,
  input  wire logic           pop,
  output tsa_pkg::item_t      rdata
);

  tsa_pkg::item_t mem_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  logic           wr;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rdata = mem_r[rp_r];
  assign wr    = ctl_in.push && !ctl_in.full;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tsa_back.sv
// Back end: table walks for sweep and lookup, table updates, result register.
`default_nettype none
`include "tcp_syn_auth_filter_macros.svh"

module tsa_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire tsa_pkg::item_t q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tsa_pkg::res_t       out_res
);

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [63:0] expiry;
  } a_ent_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] pair;
    logic [31:0] ports;
    logic [63:0] expiry;
  } p_ent_t;

  a_ent_t a_mem [tsa_pkg::ALLOW_DEPTH];
  p_ent_t p_mem [tsa_pkg::PEND_DEPTH];

  tsa_pkg::state_t state_r, state_nxt;
  logic [tsa_pkg::CNT_AW-1:0]   cnt_r, cnt_nxt;
  logic [63:0]                  next_sweep_r;

  logic                         a_re, p_re;
  logic                         a_we, p_we;
  logic [tsa_pkg::ALLOW_AW-1:0] a_waddr;
  logic [tsa_pkg::PEND_AW-1:0]  p_waddr;
  a_ent_t                       a_wdata, a_rd_r;
  p_ent_t                       p_wdata, p_rd_r;
  logic                         rd_a_vld_r, rd_p_vld_r;
  logic [tsa_pkg::CNT_AW-1:0]   rd_idx_r;

  logic                         sweep_r;
  logic                         allowed_r, present_r;
  logic                         afree_vld_r, phit_vld_r, pfree_vld_r;
  logic [tsa_pkg::ALLOW_AW-1:0] afree_idx_r;
  logic [tsa_pkg::PEND_AW-1:0]  phit_idx_r, pfree_idx_r;

  logic            a_clr, a_ev, a_eq, p_clr, p_ev, p_eq;
  logic            fin_go, start;
  logic            new_a_we, new_p_we;
  logic [tsa_pkg::PEND_AW-1:0] new_p_idx;
  tsa_pkg::res_t   res;
  logic            out_vld_r;
  tsa_pkg::res_t   out_res_r;

  assign start  = (state_r == tsa_pkg::ST_IDLE) && q_valid;
  assign fin_go = (state_r == tsa_pkg::ST_FINISH) && (!out_vld_r || out_ready);
  assign q_pop  = fin_go;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsa_pkg::ST_CLEAR: begin
        if (cnt_r == tsa_pkg::CNT_AW'(tsa_pkg::CLR_DEPTH - 1)) state_nxt = tsa_pkg::ST_IDLE;
      end
      tsa_pkg::ST_IDLE: begin
        if (q_valid) state_nxt = tsa_pkg::ST_ASCAN;
      end
      tsa_pkg::ST_ASCAN: begin
        if (cnt_r == tsa_pkg::CNT_AW'(tsa_pkg::ALLOW_DEPTH - 1)) state_nxt = tsa_pkg::ST_PSCAN;
      end
      tsa_pkg::ST_PSCAN: begin
        if (cnt_r == tsa_pkg::CNT_AW'(tsa_pkg::PEND_DEPTH - 1)) state_nxt = tsa_pkg::ST_DRAIN;
      end
      tsa_pkg::ST_DRAIN: begin
        state_nxt = tsa_pkg::ST_FINISH;
      end
      tsa_pkg::ST_FINISH: begin
        if (fin_go) state_nxt = tsa_pkg::ST_IDLE;
      end
      default: state_nxt = tsa_pkg::ST_IDLE;
    endcase
  end

  // per-entry checks on the word read last cycle; sweep clears come first
  always_comb begin
    a_clr = rd_a_vld_r && a_rd_r.valid && sweep_r && (a_rd_r.expiry < q_rdata.now);
    a_ev  = a_rd_r.valid && !a_clr;
    a_eq  = a_rd_r.key == q_rdata.pair;
    p_clr = rd_p_vld_r && p_rd_r.valid && sweep_r && (p_rd_r.expiry < q_rdata.now);
    p_ev  = p_rd_r.valid && !p_clr;
    p_eq  = (p_rd_r.pair == q_rdata.pair) && (p_rd_r.ports == q_rdata.ports);
  end

  // decision once both walks are done
  always_comb begin
    res       = '0;
    new_a_we  = 1'b0;
    new_p_we  = 1'b0;
    new_p_idx = phit_vld_r ? phit_idx_r : pfree_idx_r;
    case (q_rdata.op)
      tsa_pkg::OP_SYN: begin
        if (!allowed_r) begin
          res.reply_kind = tsa_pkg::KIND_SYNACK;
          new_p_we       = phit_vld_r || pfree_vld_r;
          res.table_full = !(phit_vld_r || pfree_vld_r);
        end
      end
      tsa_pkg::OP_ACK: begin
        if (phit_vld_r) begin
          res.reply_kind = tsa_pkg::KIND_RST;
          new_a_we       = !present_r && afree_vld_r;
          res.table_full = !present_r && !afree_vld_r;
        end
      end
      default: ;
    endcase
    res.pass_to_host = (res.reply_kind == tsa_pkg::KIND_NONE) && q_rdata.flen_ok;
    if (res.reply_kind != tsa_pkg::KIND_NONE) begin
      res.reply_src_addr = q_rdata.pair[31:0];
      res.reply_dst_addr = q_rdata.pair[63:32];
      res.reply_src_port = q_rdata.ports[15:0];
      res.reply_dst_port = q_rdata.ports[31:16];
    end
    if (res.reply_kind == tsa_pkg::KIND_SYNACK) begin
      res.reply_seq = q_rdata.sseq;
      res.reply_ack = q_rdata.seq_inc;
    end else if (res.reply_kind == tsa_pkg::KIND_RST) begin
      res.reply_seq = q_rdata.ackn;
      res.reply_ack = q_rdata.seq;
    end
  end

  // memory ports and counter
  always_comb begin
    a_re    = 1'b0;
    p_re    = 1'b0;
    cnt_nxt = cnt_r;
    a_we    = 1'b0;
    p_we    = 1'b0;
    a_waddr = rd_idx_r[tsa_pkg::ALLOW_AW-1:0];
    p_waddr = rd_idx_r[tsa_pkg::PEND_AW-1:0];
    a_wdata = '0;
    p_wdata = '0;
    unique case (state_r)
      tsa_pkg::ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        a_we    = {1'b0, cnt_r} < (tsa_pkg::CNT_AW + 1)'(tsa_pkg::ALLOW_DEPTH);
        p_we    = {1'b0, cnt_r} < (tsa_pkg::CNT_AW + 1)'(tsa_pkg::PEND_DEPTH);
        a_waddr = cnt_r[tsa_pkg::ALLOW_AW-1:0];
        p_waddr = cnt_r[tsa_pkg::PEND_AW-1:0];
        if (state_nxt == tsa_pkg::ST_IDLE) cnt_nxt = '0;
      end
      tsa_pkg::ST_IDLE: begin
        cnt_nxt = '0;
      end
      tsa_pkg::ST_ASCAN: begin
        a_re    = 1'b1;
        cnt_nxt = (state_nxt == tsa_pkg::ST_PSCAN) ? '0 : cnt_r + 1'b1;
      end
      tsa_pkg::ST_PSCAN: begin
        p_re    = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
      tsa_pkg::ST_DRAIN: ;
      tsa_pkg::ST_FINISH: begin
        if (fin_go) begin
          a_we           = new_a_we;
          a_waddr        = afree_idx_r;
          a_wdata.valid  = 1'b1;
          a_wdata.key    = q_rdata.pair;
          a_wdata.expiry = q_rdata.exp_allow;
          p_we           = new_p_we;
          p_waddr        = new_p_idx;
          p_wdata.valid  = 1'b1;
          p_wdata.pair   = q_rdata.pair;
          p_wdata.ports  = q_rdata.ports;
          p_wdata.expiry = q_rdata.exp_syn;
        end
      end
      default: ;
    endcase
    // sweep clears of the word under test; other fields left as written
    if (a_clr) begin
      a_we    = 1'b1;
      a_wdata = a_rd_r;
      a_wdata.valid = 1'b0;
    end
    if (p_clr) begin
      p_we    = 1'b1;
      p_wdata = p_rd_r;
      p_wdata.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_waddr] <= a_wdata;
    if (a_re) a_rd_r <= a_mem[cnt_r[tsa_pkg::ALLOW_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (p_we) p_mem[p_waddr] <= p_wdata;
    if (p_re) p_rd_r <= p_mem[cnt_r[tsa_pkg::PEND_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tsa_pkg::ST_CLEAR;
      cnt_r        <= '0;
      rd_a_vld_r   <= 1'b0;
      rd_p_vld_r   <= 1'b0;
      next_sweep_r <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rd_a_vld_r <= a_re;
      rd_p_vld_r <= p_re;
      if (start && (next_sweep_r < q_rdata.now)) begin
        next_sweep_r <= q_rdata.next_sweep;
      end
      if (fin_go) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // walk flags; lowest index wins since the walk counts up
  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (fin_go) out_res_r <= res;
    if (start) begin
      sweep_r     <= next_sweep_r < q_rdata.now;
      allowed_r   <= 1'b0;
      present_r   <= 1'b0;
      afree_vld_r <= 1'b0;
      phit_vld_r  <= 1'b0;
      pfree_vld_r <= 1'b0;
    end else begin
      if (rd_a_vld_r) begin
        if (a_ev && a_eq) present_r <= 1'b1;
        if (a_ev && a_eq && (a_rd_r.expiry >= q_rdata.now)) allowed_r <= 1'b1;
        if (!a_ev && !afree_vld_r) begin
          afree_vld_r <= 1'b1;
          afree_idx_r <= rd_idx_r[tsa_pkg::ALLOW_AW-1:0];
        end
      end
      if (rd_p_vld_r) begin
        if (p_ev && p_eq && !phit_vld_r) begin
          phit_vld_r <= 1'b1;
          phit_idx_r <= rd_idx_r[tsa_pkg::PEND_AW-1:0];
        end
        if (!p_ev && !pfree_vld_r) begin
          pfree_vld_r <= 1'b1;
          pfree_idx_r <= rd_idx_r[tsa_pkg::PEND_AW-1:0];
        end
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  `TSA_ASSERT_NOW(a_one_walk, clk, rst_n, rd_a_vld_r, !rd_p_vld_r, "both table walks active")
  `TSA_ASSERT_NOW(a_pop_fin, clk, rst_n, q_pop, q_valid && (state_r == tsa_pkg::ST_FINISH), "pop outside finish")
  `TSA_ASSERT_NEXT(a_pop_out, clk, rst_n, q_pop, out_vld_r && (state_r == tsa_pkg::ST_IDLE), "result not loaded")
  `TSA_ASSERT_NOW(a_new_pend, clk, rst_n, fin_go && new_p_we, q_rdata.op == tsa_pkg::OP_SYN, "pending write without SYN")

endmodule

`default_nettype wire

>>> hw/rtl/tcp_syn_auth_filter.sv
// Top level of the TCP SYN authentication filter: register file and stream ports.
//
//  port group | dir | beat contents
//  in_*       | in  | one parsed TCP/IP header
//  out_*      | out | verdict and reply for one header
//  cfg_*      | in  | APB register writes and reads
//
// Each header walks both tables, one entry a cycle through a single read
// port each, sweeping and matching. After reset a clearing pass over all
// max(ALLOW_DEPTH, PEND_DEPTH) = 1024 entries runs before the first header
// is processed; headers are still queued, up to two.
// A stalled out_tready holds one result; the queue keeps taking beats meanwhile.
`default_nettype none

module tcp_syn_auth_filter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // now, is_tcp, src_addr, dst_addr, src_port, dst_port, syn_flag, ack_flag,
  // seq_num, ack_num, server_seq, frame_length
  input  wire logic [tsa_pkg::IN_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // pass_to_host, reply_src_addr, reply_dst_addr, reply_src_port,
  // reply_dst_port, reply_seq, reply_ack, table_full
  output logic [tsa_pkg::OUT_W-1:0]        out_tdata,
  // reply_kind
  output logic [1:0]                       out_tuser,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [tsa_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [tsa_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tsa_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);

  tsa_pkg::cfg_t   cfg_r;
  logic [2:0]      reg_idx;
  logic            cfg_wr;
  logic            q_full, q_valid, q_pop;
  tsa_pkg::q_ctl_t q_ctl;
  tsa_pkg::item_t  q_wdata, q_rdata;
  tsa_pkg::res_t   res;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{watch_addr: '0, watch_count: 3'd0, allow_time: 32'd60000,
                 syn_wait_time: 32'd5000, sweep_interval: 32'd1000};
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tsa_pkg::REG_WATCH0: cfg_r.watch_addr[0]  <= cfg_pwdata;
        tsa_pkg::REG_WATCH1: cfg_r.watch_addr[1]  <= cfg_pwdata;
        tsa_pkg::REG_WATCH2: cfg_r.watch_addr[2]  <= cfg_pwdata;
        tsa_pkg::REG_WATCH3: cfg_r.watch_addr[3]  <= cfg_pwdata;
        tsa_pkg::REG_WCOUNT: cfg_r.watch_count    <= cfg_pwdata[2:0];
        tsa_pkg::REG_ALLOW:  cfg_r.allow_time     <= cfg_pwdata;
        tsa_pkg::REG_WAIT:   cfg_r.syn_wait_time  <= cfg_pwdata;
        tsa_pkg::REG_SWEEP:  cfg_r.sweep_interval <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tsa_pkg::REG_WATCH0: cfg_prdata = cfg_r.watch_addr[0];
      tsa_pkg::REG_WATCH1: cfg_prdata = cfg_r.watch_addr[1];
      tsa_pkg::REG_WATCH2: cfg_prdata = cfg_r.watch_addr[2];
      tsa_pkg::REG_WATCH3: cfg_prdata = cfg_r.watch_addr[3];
      tsa_pkg::REG_WCOUNT: cfg_prdata = {29'd0, cfg_r.watch_count};
      tsa_pkg::REG_ALLOW:  cfg_prdata = cfg_r.allow_time;
      tsa_pkg::REG_WAIT:   cfg_prdata = cfg_r.syn_wait_time;
      tsa_pkg::REG_SWEEP:  cfg_prdata = cfg_r.sweep_interval;
      default:             cfg_prdata = '0;
    endcase
  end

  tsa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_ctl.push),
    .q_wdata   (q_wdata)
  );

  assign q_ctl.full = q_full;

  tsa_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (q_ctl),
    .full   (q_full),
    .wdata  (q_wdata),
    .valid  (q_valid),
    .pop    (q_pop),
    .rdata  (q_rdata)
  );

  tsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = res.reply_kind;
  assign out_tdata = {6'd0, res.table_full, res.reply_ack, res.reply_seq,
                      res.reply_dst_port, res.reply_src_port, res.reply_dst_addr,
                      res.reply_src_addr, res.pass_to_host};

endmodule

`default_nettype wire

>>> sim/tcp_syn_auth_filter_chk.sv
// Checker for the SYN authentication filter: predicts each verdict and compares it.
`default_nettype none

module tcp_syn_auth_filter_chk (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  input  wire logic                        in_tready,
  input  wire logic [tsa_pkg::IN_W-1:0]    in_tdata,
  input  wire logic                        out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic [tsa_pkg::OUT_W-1:0]   out_tdata,
  input  wire logic [1:0]                  out_tuser,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [tsa_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [tsa_pkg::CFG_DW-1:0]  cfg_pwdata,
  input  wire logic                        cfg_pready,
  output int                               errors,
  output int                               owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [31:0] watch [4];
  logic [2:0]  wcount;
  logic [31:0] grant_ticks, hold_ticks, sweep_ticks;

  // authenticated pairs
  logic [63:0] akey [tsa_pkg::ALLOW_DEPTH];
  logic [63:0] aexp [tsa_pkg::ALLOW_DEPTH];
  bit          avld [tsa_pkg::ALLOW_DEPTH];
  // half-open handshakes
  logic [63:0] hpair  [tsa_pkg::PEND_DEPTH];
  logic [31:0] hports [tsa_pkg::PEND_DEPTH];
  logic [63:0] hexp   [tsa_pkg::PEND_DEPTH];
  bit          hvld   [tsa_pkg::PEND_DEPTH];
  logic [63:0] sweep_due;

  tsa_pkg::res_t verdicts_due [$];

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [31:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {33'd0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic screen_header(input logic [tsa_pkg::IN_W-1:0] d, output tsa_pkg::res_t r);
    logic [63:0] now, pair;
    logic        tcp, syn, ack, watched, allowed, present;
    logic [31:0] src, dst, seq, ackn, sseq, ports;
    logic [15:0] sp, dp, flen;
    int          n, hit, slot;
    now  = d[63:0];     tcp  = d[64];
    src  = d[96:65];    dst  = d[128:97];
    sp   = d[144:129];  dp   = d[160:145];
    syn  = d[161];      ack  = d[162];
    seq  = d[194:163];  ackn = d[226:195];
    sseq = d[258:227];  flen = d[274:259];
    r = '0;
    r.reply_kind = tsa_pkg::KIND_NONE;
    pair  = {src, dst};
    ports = {sp, dp};
    if (sweep_due < now) begin
      for (int i = 0; i < tsa_pkg::ALLOW_DEPTH; i++)
        if (avld[i] && aexp[i] < now) avld[i] = 0;
      for (int i = 0; i < tsa_pkg::PEND_DEPTH; i++)
        if (hvld[i] && hexp[i] < now) hvld[i] = 0;
      sweep_due = add_sat(now, sweep_ticks);
    end
    n = (wcount > 4) ? 4 : wcount;
    watched = 0;
    for (int i = 0; i < n; i++) if (watch[i] == dst) watched = 1;
    if (tcp && watched && syn && !ack) begin
      allowed = 0;
      for (int i = 0; i < tsa_pkg::ALLOW_DEPTH; i++)
        if (avld[i] && akey[i] == pair && aexp[i] >= now) allowed = 1;
      if (!allowed) begin
        r.reply_kind = tsa_pkg::KIND_SYNACK;
        r.reply_seq  = sseq;
        r.reply_ack  = seq + 32'd1;
        hit = -1; slot = -1;
        for (int i = 0; i < tsa_pkg::PEND_DEPTH; i++) begin
          if (hvld[i]) begin
            if (hit < 0 && hpair[i] == pair && hports[i] == ports) hit = i;
          end else if (slot < 0) slot = i;
        end
        if (hit < 0 && slot >= 0) begin
          hit = slot;
          hvld[hit] = 1; hpair[hit] = pair; hports[hit] = ports;
        end
        if (hit >= 0) hexp[hit] = add_sat(now, hold_ticks);
        else r.table_full = 1;
      end
    end else if (tcp && watched && !syn && ack) begin
      hit = -1;
      for (int i = 0; i < tsa_pkg::PEND_DEPTH; i++)
        if (hvld[i] && hpair[i] == pair && hports[i] == ports) hit = i;
      if (hit >= 0) begin
        r.reply_kind = tsa_pkg::KIND_RST;
        r.reply_seq  = ackn;
        r.reply_ack  = seq;
        present = 0; slot = -1;
        for (int i = 0; i < tsa_pkg::ALLOW_DEPTH; i++) begin
          if (avld[i]) begin
            if (akey[i] == pair) present = 1;
          end else if (slot < 0) slot = i;
        end
        if (!present) begin
          if (slot >= 0) begin
            avld[slot] = 1; akey[slot] = pair; aexp[slot] = add_sat(now, grant_ticks);
          end else r.table_full = 1;
        end
      end
    end
    if (r.reply_kind != tsa_pkg::KIND_NONE) begin
      r.reply_src_addr = dst; r.reply_dst_addr = src;
      r.reply_src_port = dp;  r.reply_dst_port = sp;
    end
    r.pass_to_host = (r.reply_kind == tsa_pkg::KIND_NONE) &&
                     (flen <= tsa_pkg::MAX_FRAME - tsa_pkg::FRAME_SLACK);
  endtask

  always @(posedge clk) begin
    tsa_pkg::res_t e, a;
    if (!rst_n) begin
      foreach (watch[i]) watch[i] = '0;
      wcount = '0;
      grant_ticks = 32'd60000; hold_ticks = 32'd5000; sweep_ticks = 32'd1000;
      foreach (avld[i]) avld[i] = 0;
      foreach (hvld[i]) hvld[i] = 0;
      sweep_due = '0;
      verdicts_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          tsa_pkg::REG_WATCH0, tsa_pkg::REG_WATCH1, tsa_pkg::REG_WATCH2,
          tsa_pkg::REG_WATCH3:
            watch[cfg_paddr[3:2]] = cfg_pwdata;
          tsa_pkg::REG_WCOUNT: wcount      = cfg_pwdata[2:0];
          tsa_pkg::REG_ALLOW:  grant_ticks = cfg_pwdata;
          tsa_pkg::REG_WAIT:   hold_ticks  = cfg_pwdata;
          tsa_pkg::REG_SWEEP:  sweep_ticks = cfg_pwdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        screen_header(in_tdata, e);
        verdicts_due.push_back(e);
      end
      if (out_tvalid && out_tready) begin
        if (verdicts_due.size() == 0) begin
          report("unexpected beat", out_tdata[63:0], '0);
        end else begin
          e = verdicts_due.pop_front();
          a.pass_to_host   = out_tdata[0];
          a.reply_src_addr = out_tdata[32:1];
          a.reply_dst_addr = out_tdata[64:33];
          a.reply_src_port = out_tdata[80:65];
          a.reply_dst_port = out_tdata[96:81];
          a.reply_seq      = out_tdata[128:97];
          a.reply_ack      = out_tdata[160:129];
          a.table_full     = out_tdata[161];
          if (a.pass_to_host !== e.pass_to_host)
            report("pass_to_host", a.pass_to_host, e.pass_to_host);
          if (out_tuser !== e.reply_kind) report("reply_kind", out_tuser, e.reply_kind);
          if (a.reply_src_addr !== e.reply_src_addr)
            report("reply_src_addr", a.reply_src_addr, e.reply_src_addr);
          if (a.reply_dst_addr !== e.reply_dst_addr)
            report("reply_dst_addr", a.reply_dst_addr, e.reply_dst_addr);
          if (a.reply_src_port !== e.reply_src_port)
            report("reply_src_port", a.reply_src_port, e.reply_src_port);
          if (a.reply_dst_port !== e.reply_dst_port)
            report("reply_dst_port", a.reply_dst_port, e.reply_dst_port);
          if (a.reply_seq !== e.reply_seq) report("reply_seq", a.reply_seq, e.reply_seq);
          if (a.reply_ack !== e.reply_ack) report("reply_ack", a.reply_ack, e.reply_ack);
          if (a.table_full !== e.table_full)
            report("table_full", a.table_full, e.table_full);
        end
      end
    end
    owed = verdicts_due.size();
  end

  initial begin
    errors = 0;
    owed = 0;
  end

endmodule

`default_nettype wire

>>> sim/tb_tcp_syn_auth_filter.sv
// Top of the filter testbench: clock, reset, header stimulus, register writes, verdict.
`default_nettype none

module tb_tcp_syn_auth_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [tsa_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [tsa_pkg::OUT_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [tsa_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [tsa_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [tsa_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;
  int errors, owed;

  logic [63:0] tnow = 64'd1;
  logic [31:0] gate [4];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  tcp_syn_auth_filter i_dut (.*);

  tcp_syn_auth_filter_chk i_chk (.*);

  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) out_tready <= 1;
    else if (r < 97) out_tready <= 0;
    else begin
      out_tready <= 0;
      repeat ($urandom_range(10, 60)) @(negedge clk);
    end
  end

  // idle watchdog
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [tsa_pkg::IN_W-1:0] hdr(logic tcp, logic [31:0] src,
      logic [31:0] dst, logic [15:0] sp, logic [15:0] dp, logic syn, logic ack,
      logic [31:0] seq, logic [31:0] ackn, logic [31:0] sseq, logic [15:0] flen);
    return {5'd0, flen, sseq, ackn, seq, ack, syn, dp, sp, dst, src, tcp, tnow};
  endfunction

  task automatic send(logic [tsa_pkg::IN_W-1:0] d);
    int g;
    g = pick_gap();
    @(negedge clk);
    if (g > 0) begin
      in_tvalid = 0;
      repeat (g) @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 0;
    while (owed != 0) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_psel = 1; cfg_penable = 0; cfg_pwrite = 1;
    cfg_paddr = {idx, 2'b00}; cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
  endtask

  task automatic set_times(logic [31:0] grant, logic [31:0] hold, logic [31:0] sw);
    reg_write(tsa_pkg::REG_ALLOW, grant);
    reg_write(tsa_pkg::REG_WAIT, hold);
    reg_write(tsa_pkg::REG_SWEEP, sw);
  endtask

  task automatic set_watch(logic [2:0] cnt);
    for (int i = 0; i < 4; i++) reg_write(tsa_pkg::REG_WATCH0 + 3'(i), gate[i]);
    reg_write(tsa_pkg::REG_WCOUNT, {29'd0, cnt});
  endtask

  // plain SYN / ACK helpers for one flow
  task automatic syn_to(logic [31:0] s, logic [31:0] d, logic [15:0] sp, logic [15:0] dp);
    send(hdr(1, s, d, sp, dp, 1, 0, $urandom, $urandom, $urandom, $urandom_range(40, 1500)));
  endtask

  task automatic ack_to(logic [31:0] s, logic [31:0] d, logic [15:0] sp, logic [15:0] dp);
    send(hdr(1, s, d, sp, dp, 0, 1, $urandom, $urandom, $urandom, $urandom_range(40, 1500)));
  endtask

  // mostly handshakes over small pools, some noise
  task automatic random_traffic(int count);
    logic [31:0] s, d;
    logic [15:0] sp, dp;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) tnow += $urandom_range(1000, 200000);
      else tnow += $urandom_range(0, 300);
      s  = 32'h0a00_0000 + $urandom_range(0, 7);
      d  = ($urandom_range(0, 4) == 0) ? $urandom : gate[$urandom_range(0, 3)];
      sp = 16'd1024 + $urandom_range(0, 3);
      dp = ($urandom_range(0, 1) == 0) ? 16'd80 : 16'd443;
      if (r < 40) syn_to(s, d, sp, dp);
      else if (r < 75) ack_to(s, d, sp, dp);
      else send(hdr($urandom, $urandom, (r < 88) ? d : $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      if (k == count / 2 && $urandom_range(0, 1)) drain();
    end
  endtask

  initial begin
    logic [31:0] a, b;
    gate[0] = 32'hc0a8_0001; gate[1] = 32'hc0a8_0002;
    gate[2] = 32'h0000_0000; gate[3] = 32'hffff_ffff;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    set_watch(3'd4);
    set_times(32'd3000, 32'd2000, 32'd500);
    a = 32'h0a00_0001; b = gate[0];
    // frame length boundary, no reply involved
    send(hdr(0, a, b, 16'd1, 16'd80, 1, 0, 1, 2, 3, 16'd2046));
    send(hdr(1, a, b, 16'd1, 16'd80, 1, 1, 1, 2, 3, 16'd2047));
    send(hdr(1, a, b, 16'd1, 16'd80, 0, 0, 1, 2, 3, 16'hffff));
    send(hdr(1, a, 32'h1234_5678, 16'd1, 16'd80, 1, 0, 1, 2, 3, 16'd0));
    // SYN with wrapping sequence, then renewal of the same record
    send(hdr(1, a, b, 16'd1, 16'd80, 1, 0, 32'hffff_ffff, 0, 32'hdead_beef, 16'd60));
    tnow += 10;
    send(hdr(1, a, b, 16'd1, 16'd80, 1, 0, 32'h7fff_ffff, 0, 32'h0, 16'd60));
    send(hdr(1, a, b, 16'd2, 16'd80, 0, 1, 5, 6, 7, 16'd60));  // wrong port
    send(hdr(1, a, b, 16'd1, 16'd80, 0, 1, 32'hffff_ffff, 32'hffff_ffff, 7, 16'd60));
    send(hdr(1, a, b, 16'd1, 16'd80, 0, 1, 8, 9, 7, 16'd60));  // key already allowed
    send(hdr(1, a, b, 16'd1, 16'd80, 1, 0, 8, 9, 7, 16'd60));  // allowed, passes
    // pending record expires before its ACK, and the sweep on the ACK clears it
    tnow += 2100;
    syn_to(32'h0a00_0002, gate[1], 16'hffff, 16'h0000);
    tnow += 2500;
    ack_to(32'h0a00_0002, gate[1], 16'hffff, 16'h0000);
    // sweep clears the expired allow entry
    tnow += 4000;
    syn_to(a, b, 16'd1, 16'd80);
    syn_to(32'hffff_ffff, gate[2], 16'hffff, 16'hffff);
    ack_to(32'hffff_ffff, gate[2], 16'hffff, 16'hffff);
    syn_to(32'h0, gate[3], 16'h0, 16'h0);
    drain();

    // watch count above four, then nothing watched
    reg_write(tsa_pkg::REG_WCOUNT, 32'd7);
    syn_to(32'h0a00_0003, gate[3], 16'd5, 16'd25);
    ack_to(32'h0a00_0003, gate[3], 16'd5, 16'd25);
    drain();
    reg_write(tsa_pkg::REG_WCOUNT, 32'd0);
    syn_to(32'h0a00_0004, gate[0], 16'd5, 16'd25);
    drain();

    set_watch(3'd4);
    set_times(32'd5000, 32'd3000, 32'd1000);
    random_traffic(120);
    drain();
    set_times(32'd0, 32'd0, 32'd0);
    random_traffic(80);
    drain();
    gate[1] = $urandom;
    set_watch(3'd2);
    set_times($urandom_range(100, 20000), $urandom_range(100, 20000), $urandom_range(0, 5000));
    random_traffic(80);
    drain();

    // one sweep empties both tables, fill them without further sweeps, then overflow them
    gate[0] = 32'hac10_0001;
    set_watch(3'd1);
    set_times(32'd1_000_000, 32'd1_000_000, 32'd10_000_000);
    tnow += 64'd50_000_000;
    for (int k = 0; k < 1030; k++) begin
      tnow += 1;
      syn_to(32'h6400_0000 + k, gate[0], 16'd7, 16'd80);
      if (k < 262) ack_to(32'h6400_0000 + k, gate[0], 16'd7, 16'd80);
    end
    syn_to(32'h6500_0000, gate[0], 16'd7, 16'd80);
    syn_to(32'h6400_0010, gate[0], 16'd8, 16'd80);
    ack_to(32'h6400_0300, gate[0], 16'd7, 16'd80);
    ack_to(32'h6400_0301, gate[0], 16'd7, 16'd80);
    drain();

    // let the sweep empty everything, random again
    set_watch(3'd4);
    set_times(32'hffff_ffff, 32'd4000, 32'd200);
    tnow += 64'd100_000_000;
    random_traffic(140);
    drain();

    // time at its top: sums saturate
    tnow = 64'hffff_ffff_ffff_f000;
    syn_to(32'h0a00_0005, gate[0], 16'd9, 16'd22);
    ack_to(32'h0a00_0005, gate[0], 16'd9, 16'd22);
    tnow = '1;
    syn_to(32'h0a00_0006, gate[3], 16'd9, 16'd22);
    ack_to(32'h0a00_0006, gate[3], 16'd9, 16'd22);
    syn_to(32'h0a00_0005, gate[0], 16'd9, 16'd22);
    drain();
    repeat (50) @(posedge clk);

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
